// ----- sv/i2crms_pkg.sv -----
// Shared constants, register codes and controller/datapath interface types
// for the I2C register-map slave. No dependencies.
package i2crms_pkg;

    // Default channel counts
    localparam int PWM_CHANNELS_DEF = 8;
    localparam int ADC_CHANNELS_DEF = 16;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int LIDX_W    = 4;
    localparam int SAMPLE_W  = 16;
    localparam int STORE_AW  = 6;
    localparam int STORE_D   = 64;
    localparam int PCH_W     = 3;
    localparam int ACH_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int GPIO_BYTES = 3;

    // Item commands
    localparam logic [CMD_W-1:0] CMD_XFER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADC  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GPIO = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SW_REV    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_HIGH = 2'd3;

    // Register map codes
    localparam logic [BYTE_W-1:0] CODE_NOCHANGE  = 8'h00;
    localparam logic [BYTE_W-1:0] CODE_REV       = 8'h01;
    localparam logic [BYTE_W-1:0] CODE_PWM0      = 8'h02;
    localparam logic [BYTE_W-1:0] CODE_PWM7      = 8'h09;
    localparam logic [BYTE_W-1:0] CODE_ADC_FIRST = 8'h14;
    localparam logic [BYTE_W-1:0] CODE_ADC_LAST  = 8'h33;
    localparam logic [BYTE_W-1:0] CODE_GPIO0     = 8'h34;
    localparam logic [BYTE_W-1:0] CODE_GPIO1     = 8'h35;
    localparam logic [BYTE_W-1:0] CODE_MODE0     = 8'h36;
    localparam logic [BYTE_W-1:0] CODE_MODE1     = 8'h37;
    localparam logic [BYTE_W-1:0] CODE_SOFTOC    = 8'h38;
    localparam logic [BYTE_W-1:0] CODE_INVALID   = 8'h39;
    localparam logic [BYTE_W-1:0] CODE_DEBUG     = 8'hFE;

    localparam logic [STORE_AW-1:0] IDX_INVALID  = 6'h39;
    localparam logic [BYTE_W-1:0]   BYTE_INVALID = 8'hFF;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch the accepted input word
        logic exec;      // apply writes/loads, store the read byte
        logic wr_hi;     // store the ADC high byte
        logic rd;        // read the store at the last code
        logic out_load;  // move the result into the output register
    } i2crms_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic need_hi;   // current item is an ADC LSB read
    } i2crms_sts_t;

endpackage

// ----- sv/i2crms_ctrl.sv -----
// Sequencing controller for the I2C register-map slave.
// Depends on i2crms_pkg for the command and status types.
module i2crms_ctrl
    import i2crms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  i2crms_sts_t sts,
    output i2crms_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_WRHI = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // Step through one item at a time
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.need_hi ? ST_WRHI : ST_READ;
            end
            ST_WRHI:
            begin
                cmd.wr_hi  = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Track the output word
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- sv/i2crms_dpath.sv -----
// Datapath for the I2C register-map slave: config, PWM/ADC/GPIO state,
// response store memory and output register. Depends on i2crms_pkg.
module i2crms_dpath
    import i2crms_pkg::*;
#(
    parameter int PWM_CHANNELS = PWM_CHANNELS_DEF,
    parameter int ADC_CHANNELS = ADC_CHANNELS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wdata,
    input  logic [CMD_W-1:0]     command,
    input  logic [BYTE_W-1:0]    dev_addr,
    input  logic [BYTE_W-1:0]    reg_code,
    input  logic [BYTE_W-1:0]    wdata,
    input  logic                 has_payload,
    input  logic [LIDX_W-1:0]    load_index,
    input  logic [SAMPLE_W-1:0]  load_value,
    input  i2crms_cmd_t          cmd,
    output i2crms_sts_t          sts,
    output logic [BYTE_W-1:0]    rdata,
    output logic                 addressed,
    output logic                 latch_reset,
    output logic                 pwm_written,
    output logic [PCH_W-1:0]     pwm_channel,
    output logic [BYTE_W-1:0]    pwm_value
);

    localparam int PW = (PWM_CHANNELS > 1) ? $clog2(PWM_CHANNELS) : 1;
    localparam int AW = (ADC_CHANNELS > 1) ? $clog2(ADC_CHANNELS) : 1;

    // Configuration registers
    logic [BYTE_W-1:0] dev_addr_reg;
    logic [BYTE_W-1:0] sw_rev_reg;
    logic [BYTE_W-1:0] mode_low_reg;
    logic [BYTE_W-1:0] mode_high_reg;

    // Captured input word
    logic [CMD_W-1:0]    cmd_q_reg;
    logic [BYTE_W-1:0]   addr_q_reg;
    logic [BYTE_W-1:0]   code_q_reg;
    logic [BYTE_W-1:0]   wdata_q_reg;
    logic                pay_q_reg;
    logic [LIDX_W-1:0]   lidx_q_reg;
    logic [SAMPLE_W-1:0] lval_q_reg;

    // Map state
    logic [BYTE_W-1:0]   pwm_level_reg [PWM_CHANNELS];
    logic [SAMPLE_W-1:0] adc_sample_reg [ADC_CHANNELS];
    logic [BYTE_W-1:0]   gpio_byte_reg [GPIO_BYTES];
    logic [BYTE_W-1:0]   debug_reg;
    logic [STORE_AW-1:0] last_idx_reg;
    logic [BYTE_W-1:0]   hi_byte_reg;

    // Response store
    logic [BYTE_W-1:0]   store_mem [STORE_D];
    logic [STORE_D-1:0]  store_valid_reg;
    logic [BYTE_W-1:0]   rd_data_reg;

    // Pending result flags
    logic                addr_p_reg;
    logic                latch_p_reg;
    logic                pw_p_reg;
    logic [PCH_W-1:0]    pch_p_reg;
    logic [BYTE_W-1:0]   pval_p_reg;

    // Output register
    logic [BYTE_W-1:0]   rdata_reg;
    logic                addressed_reg;
    logic                latch_reg;
    logic                pw_reg;
    logic [PCH_W-1:0]    pch_reg;
    logic [BYTE_W-1:0]   pval_reg;

    // Decode signals
    logic                match;
    logic                wr_en;
    logic                is_pwm;
    logic [BYTE_W-1:0]   pch_full;
    logic [PCH_W-1:0]    pch;
    logic                pwm_ok;
    logic                pwm_wr;
    logic                latch_wr;
    logic                dbg_wr;
    logic [BYTE_W-1:0]   dbg_new;
    logic [BYTE_W-1:0]   pwm_rd;
    logic [BYTE_W-1:0]   plain_val;
    logic                is_adc;
    logic [BYTE_W-1:0]   adc_off;
    logic [ACH_W-1:0]    ach;
    logic [SAMPLE_W-1:0] sample;
    logic                adc_load;
    logic                gpio_load;
    logic                st_we;
    logic [STORE_AW-1:0] st_waddr;
    logic [BYTE_W-1:0]   st_wdata;
    logic                last_upd;
    logic [STORE_AW-1:0] last_idx_next;
    logic                need_hi;

    // Decode the captured transaction
    always_comb
    begin
        match    = (cmd_q_reg == CMD_XFER) && (addr_q_reg == dev_addr_reg);
        wr_en    = match && pay_q_reg;
        is_pwm   = (code_q_reg >= CODE_PWM0) && (code_q_reg <= CODE_PWM7);
        pch_full = code_q_reg - CODE_PWM0;
        pch      = pch_full[PCH_W-1:0];
        pwm_ok   = is_pwm && (32'(pch) < PWM_CHANNELS);
        pwm_wr   = wr_en && pwm_ok;
        latch_wr = wr_en && ((code_q_reg == CODE_GPIO0) || (code_q_reg == CODE_GPIO1));
        dbg_wr   = wr_en && (code_q_reg == CODE_DEBUG);
        dbg_new  = dbg_wr ? wdata_q_reg : debug_reg;

        // read sees the level written by the same transaction
        if (!pwm_ok)
            pwm_rd = '0;
        else if (pwm_wr)
            pwm_rd = wdata_q_reg;
        else
            pwm_rd = pwm_level_reg[pch[PW-1:0]];

        case (code_q_reg)
            CODE_REV:    plain_val = sw_rev_reg;
            CODE_GPIO0:  plain_val = gpio_byte_reg[0];
            CODE_GPIO1:  plain_val = gpio_byte_reg[1];
            CODE_MODE0:  plain_val = mode_low_reg;
            CODE_MODE1:  plain_val = mode_high_reg;
            CODE_SOFTOC: plain_val = gpio_byte_reg[2];
            default:     plain_val = is_pwm ? pwm_rd : BYTE_INVALID;
        endcase

        is_adc  = (code_q_reg >= CODE_ADC_FIRST) && (code_q_reg <= CODE_ADC_LAST);
        adc_off = code_q_reg - CODE_ADC_FIRST;
        ach     = adc_off[ACH_W:1];
        sample  = (32'(ach) < ADC_CHANNELS) ? adc_sample_reg[ach[AW-1:0]] : '0;

        adc_load  = (cmd_q_reg == CMD_ADC) && (32'(lidx_q_reg) < ADC_CHANNELS);
        gpio_load = (cmd_q_reg == CMD_GPIO) && (32'(lidx_q_reg) < GPIO_BYTES);
    end

    // Pick the store write and the new last code
    always_comb
    begin
        st_we         = 1'b0;
        st_waddr      = code_q_reg[STORE_AW-1:0];
        st_wdata      = plain_val;
        last_upd      = match && (code_q_reg != CODE_NOCHANGE);
        last_idx_next = code_q_reg[STORE_AW-1:0];
        need_hi       = 1'b0;
        if (code_q_reg == CODE_DEBUG)
        begin
            st_we         = last_upd;
            st_waddr      = IDX_INVALID;
            st_wdata      = (dbg_new != '0) ? dbg_new : BYTE_INVALID;
            last_idx_next = IDX_INVALID;
        end
        else if (code_q_reg >= CODE_INVALID)
        begin
            st_we         = last_upd;
            st_waddr      = IDX_INVALID;
            st_wdata      = BYTE_INVALID;
            last_idx_next = IDX_INVALID;
        end
        else if (is_adc)
        begin
            // LSB read locks the MSB; MSB read copies nothing
            st_we    = last_upd && !code_q_reg[0];
            st_wdata = sample[BYTE_W-1:0];
            need_hi  = last_upd && !code_q_reg[0];
        end
        else
        begin
            st_we = last_upd;
        end

        if (!cmd.exec)
        begin
            st_we = cmd.wr_hi;
            if (cmd.wr_hi)
            begin
                st_waddr = code_q_reg[STORE_AW-1:0] + STORE_AW'(1);
                st_wdata = hi_byte_reg;
            end
        end
    end

    assign sts.need_hi = need_hi;

    // Capture the input word and hold the unreset payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_q_reg   <= command;
            addr_q_reg  <= dev_addr;
            code_q_reg  <= reg_code;
            wdata_q_reg <= wdata;
            pay_q_reg   <= has_payload;
            lidx_q_reg  <= load_index;
            lval_q_reg  <= load_value;
        end
        if (cmd.exec)
        begin
            hi_byte_reg <= sample[SAMPLE_W-1:BYTE_W];
            addr_p_reg  <= match;
            latch_p_reg <= latch_wr;
            pw_p_reg    <= pwm_wr;
            pch_p_reg   <= pwm_wr ? pch : '0;
            pval_p_reg  <= pwm_wr ? wdata_q_reg : '0;
        end
        if (st_we)
            store_mem[st_waddr] <= st_wdata;
        if (cmd.rd)
            rd_data_reg <= store_valid_reg[last_idx_reg] ? store_mem[last_idx_reg] : '0;
        if (cmd.out_load)
        begin
            rdata_reg     <= rd_data_reg;
            addressed_reg <= addr_p_reg;
            latch_reg     <= latch_p_reg;
            pw_reg        <= pw_p_reg;
            pch_reg       <= pch_p_reg;
            pval_reg      <= pval_p_reg;
        end
    end

    // Update config and map state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg    <= '0;
            sw_rev_reg      <= '0;
            mode_low_reg    <= '0;
            mode_high_reg   <= '0;
            debug_reg       <= '0;
            last_idx_reg    <= '0;
            store_valid_reg <= '0;
            for (int i = 0; i < PWM_CHANNELS; i++)
                pwm_level_reg[i] <= '0;
            for (int i = 0; i < ADC_CHANNELS; i++)
                adc_sample_reg[i] <= '0;
            for (int i = 0; i < GPIO_BYTES; i++)
                gpio_byte_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEV_ADDR:  dev_addr_reg  <= cfg_wdata;
                    REG_SW_REV:    sw_rev_reg    <= cfg_wdata;
                    REG_MODE_LOW:  mode_low_reg  <= cfg_wdata;
                    REG_MODE_HIGH: mode_high_reg <= cfg_wdata;
                    default:       dev_addr_reg  <= dev_addr_reg;
                endcase
            end
            if (st_we)
                store_valid_reg[st_waddr] <= 1'b1;
            if (cmd.exec)
            begin
                if (pwm_wr)
                    pwm_level_reg[pch[PW-1:0]] <= wdata_q_reg;
                if (dbg_wr)
                    debug_reg <= wdata_q_reg;
                if (last_upd)
                    last_idx_reg <= last_idx_next;
                if (adc_load)
                    adc_sample_reg[lidx_q_reg[AW-1:0]] <= lval_q_reg;
                if (gpio_load)
                    gpio_byte_reg[lidx_q_reg[1:0]] <= lval_q_reg[BYTE_W-1:0];
            end
        end
    end

    assign rdata       = rdata_reg;
    assign addressed   = addressed_reg;
    assign latch_reset = latch_reg;
    assign pwm_written = pw_reg;
    assign pwm_channel = pch_reg;
    assign pwm_value   = pval_reg;

endmodule

// ----- sv/i2c_register_map_slave_top.sv -----
// Each accepted word passes through the controller states in order: EXEC, where it is
// decoded and applied; for an ADC low-byte read only, WRHI, because that read writes
// two bytes through the response store's single write port; READ, the response store's
// registered read; and DONE, where the result moves into the output register, waiting
// there while that register still holds an untaken result. The controller then goes
// back to idle, where the next word is taken, so a new word is accepted only once the
// last one has reached the output register. The result stays in the output register
// until taken, and the next word is accepted meanwhile. Configuration writes go straight
// to the configuration registers, without passing through the controller.
// Depends on i2crms_pkg, i2crms_ctrl and i2crms_dpath.
module i2c_register_map_slave_top
    import i2crms_pkg::*;
#(
    parameter int PWM_CHANNELS = PWM_CHANNELS_DEF,
    parameter int ADC_CHANNELS = ADC_CHANNELS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CMD_W-1:0]     command,
    input  logic [BYTE_W-1:0]    dev_addr,
    input  logic [BYTE_W-1:0]    reg_code,
    input  logic [BYTE_W-1:0]    wdata,
    input  logic                 has_payload,
    input  logic [LIDX_W-1:0]    load_index,
    input  logic [SAMPLE_W-1:0]  load_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    rdata,
    output logic                 addressed,
    output logic                 latch_reset,
    output logic                 pwm_written,
    output logic [PCH_W-1:0]     pwm_channel,
    output logic [BYTE_W-1:0]    pwm_value
);

    i2crms_cmd_t cmd;
    i2crms_sts_t sts;

    // Sequence each word
    i2crms_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Hold the register map and response store
    i2crms_dpath
    #(
        .PWM_CHANNELS (PWM_CHANNELS),
        .ADC_CHANNELS (ADC_CHANNELS)
    )
    u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .command     (command),
        .dev_addr    (dev_addr),
        .reg_code    (reg_code),
        .wdata       (wdata),
        .has_payload (has_payload),
        .load_index  (load_index),
        .load_value  (load_value),
        .cmd         (cmd),
        .sts         (sts),
        .rdata       (rdata),
        .addressed   (addressed),
        .latch_reset (latch_reset),
        .pwm_written (pwm_written),
        .pwm_channel (pwm_channel),
        .pwm_value   (pwm_value)
    );

endmodule

// ----- sv/i2crms_checker.sv -----
// Port-level checks for the I2C register-map slave, bound to the top level.
// Depends on i2crms_pkg and i2c_register_map_slave_top.
module i2crms_checker
    import i2crms_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [BYTE_W-1:0]    rdata,
    input logic                 addressed,
    input logic                 latch_reset,
    input logic                 pwm_written,
    input logic [PCH_W-1:0]     pwm_channel,
    input logic [BYTE_W-1:0]    pwm_value
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rdata))
        else $error("result word changed while stalled");

    // Take one word at a time
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word accepted while busy");

    // Drive side effects only for addressed transactions
    a_addr_fx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (latch_reset || pwm_written) |-> addressed)
        else $error("side effect without address match");

    // Keep PWM and latch pulses exclusive
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(latch_reset && pwm_written))
        else $error("PWM write and latch reset in one word");

    // Zero the PWM fields when no level was written
    a_pwm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pwm_written |-> (pwm_channel == '0) && (pwm_value == '0))
        else $error("PWM fields set without a write");

endmodule

bind i2c_register_map_slave_top i2crms_checker u_i2crms_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .rdata       (rdata),
    .addressed   (addressed),
    .latch_reset (latch_reset),
    .pwm_written (pwm_written),
    .pwm_channel (pwm_channel),
    .pwm_value   (pwm_value)
);

// ----- tb/testbench.sv -----
// Testbench for i2c_register_map_slave_top: directed and random words, checked
// against a predictor of the register map. Depends on i2crms_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
    import i2crms_pkg::*;

    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 100;
    localparam longint LIMIT_NS  = 2_000_000;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [BYTE_W-1:0]   dev_addr;
        logic [BYTE_W-1:0]   reg_code;
        logic [BYTE_W-1:0]   wdata;
        logic                has_payload;
        logic [LIDX_W-1:0]   load_index;
        logic [SAMPLE_W-1:0] load_value;
    } slave_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rdata;
        logic              addressed;
        logic              latch_reset;
        logic              pwm_written;
        logic [PCH_W-1:0]  pwm_channel;
        logic [BYTE_W-1:0] pwm_value;
    } slave_resp_t;

    typedef struct packed {
        logic        pinned;
        slave_word_t word;
        slave_resp_t resp;
    } table_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [CMD_W-1:0]     command = '0;
    logic [BYTE_W-1:0]    dev_addr = '0;
    logic [BYTE_W-1:0]    reg_code = '0;
    logic [BYTE_W-1:0]    wdata = '0;
    logic                 has_payload = 1'b0;
    logic [LIDX_W-1:0]    load_index = '0;
    logic [SAMPLE_W-1:0]  load_value = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [BYTE_W-1:0]    rdata;
    logic                 addressed;
    logic                 latch_reset;
    logic                 pwm_written;
    logic [PCH_W-1:0]     pwm_channel;
    logic [BYTE_W-1:0]    pwm_value;

    // Register copies and map state as the slave should hold them
    logic [BYTE_W-1:0]   cfg_dev_addr = '0;
    logic [BYTE_W-1:0]   cfg_sw_rev = '0;
    logic [BYTE_W-1:0]   cfg_mode_low = '0;
    logic [BYTE_W-1:0]   cfg_mode_high = '0;
    logic [BYTE_W-1:0]   map_store [STORE_D];
    logic [STORE_AW-1:0] map_last = '0;
    logic [BYTE_W-1:0]   map_pwm [PWM_CHANNELS_DEF];
    logic [SAMPLE_W-1:0] map_adc [ADC_CHANNELS_DEF];
    logic [BYTE_W-1:0]   map_gpio [GPIO_BYTES];
    logic [BYTE_W-1:0]   map_debug = '0;

    slave_resp_t awaited_resp_q [$];
    table_row_t  directed_rows [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int words_sent = 0;
    int resps_checked = 0;
    int settings_used = 0;

    i2c_register_map_slave_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .dev_addr    (dev_addr),
        .reg_code    (reg_code),
        .wdata       (wdata),
        .has_payload (has_payload),
        .load_index  (load_index),
        .load_value  (load_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rdata       (rdata),
        .addressed   (addressed),
        .latch_reset (latch_reset),
        .pwm_written (pwm_written),
        .pwm_channel (pwm_channel),
        .pwm_value   (pwm_value)
    );

    always #4 clk = ~clk;

    // Apply one word to the register map and return the response it produces
    function automatic slave_resp_t run_register_map(input slave_word_t w);
        slave_resp_t         r;
        logic [BYTE_W-1:0]   code;
        logic [BYTE_W-1:0]   offset;
        logic [STORE_AW-1:0] slot;
        logic [SAMPLE_W-1:0] sample;
        r = '0;
        code = w.reg_code;
        slot = code[STORE_AW-1:0];
        case (w.command)
            CMD_XFER:
            begin
                if (w.dev_addr == cfg_dev_addr) begin
                    r.addressed = 1'b1;
                    // Write phase comes before the read of the same code
                    if (w.has_payload) begin
                        if (code >= CODE_PWM0 && code <= CODE_PWM7) begin
                            offset = code - CODE_PWM0;
                            if (int'(offset) < PWM_CHANNELS_DEF) begin
                                map_pwm[offset[PCH_W-1:0]] = w.wdata;
                                r.pwm_written = 1'b1;
                                r.pwm_channel = offset[PCH_W-1:0];
                                r.pwm_value = w.wdata;
                            end
                        end else if (code == CODE_GPIO0 || code == CODE_GPIO1) begin
                            r.latch_reset = 1'b1;
                        end else if (code == CODE_DEBUG) begin
                            map_debug = w.wdata;
                        end
                    end
                    // Read phase: latch the code's value into the response store
                    if (code == CODE_NOCHANGE) begin
                        // keep the last code
                    end else if (code == CODE_DEBUG) begin
                        map_last = IDX_INVALID;
                        map_store[IDX_INVALID] = (map_debug != '0) ? map_debug : BYTE_INVALID;
                    end else if (code >= CODE_INVALID) begin
                        map_last = IDX_INVALID;
                        map_store[IDX_INVALID] = BYTE_INVALID;
                    end else if (code >= CODE_ADC_FIRST && code <= CODE_ADC_LAST) begin
                        // Low byte read locks the high byte; high byte read copies nothing
                        offset = code - CODE_ADC_FIRST;
                        if (!offset[0]) begin
                            sample = map_adc[offset[LIDX_W:1]];
                            map_store[slot] = sample[7:0];
                            map_store[slot + 6'd1] = sample[15:8];
                        end
                        map_last = slot;
                    end else begin
                        if (code == CODE_REV)
                            map_store[slot] = cfg_sw_rev;
                        else if (code >= CODE_PWM0 && code <= CODE_PWM7)
                            map_store[slot] = map_pwm[PCH_W'(code - CODE_PWM0)];
                        else if (code == CODE_GPIO0)
                            map_store[slot] = map_gpio[0];
                        else if (code == CODE_GPIO1)
                            map_store[slot] = map_gpio[1];
                        else if (code == CODE_MODE0)
                            map_store[slot] = cfg_mode_low;
                        else if (code == CODE_MODE1)
                            map_store[slot] = cfg_mode_high;
                        else if (code == CODE_SOFTOC)
                            map_store[slot] = map_gpio[2];
                        else
                            map_store[slot] = BYTE_INVALID;
                        map_last = slot;
                    end
                end
            end
            CMD_ADC:
            begin
                if (int'(w.load_index) < ADC_CHANNELS_DEF)
                    map_adc[w.load_index] = w.load_value;
            end
            CMD_GPIO:
            begin
                if (int'(w.load_index) < GPIO_BYTES)
                    map_gpio[w.load_index] = w.load_value[7:0];
            end
            default:
            begin
                // unused command: nothing changes
            end
        endcase
        r.rdata = map_store[map_last];
        return r;
    endfunction

    function automatic slave_word_t mk_xfer(input logic [7:0] addr, input logic [7:0] code,
                                            input logic pl, input logic [7:0] wd);
        slave_word_t w;
        w = '0;
        w.command = CMD_XFER;
        w.dev_addr = addr;
        w.reg_code = code;
        w.has_payload = pl;
        w.wdata = wd;
        return w;
    endfunction

    function automatic slave_word_t mk_load(input logic [CMD_W-1:0] cmd,
                                            input logic [LIDX_W-1:0] idx,
                                            input logic [SAMPLE_W-1:0] val);
        slave_word_t w;
        w = '0;
        w.command = cmd;
        w.load_index = idx;
        w.load_value = val;
        return w;
    endfunction

    function automatic slave_resp_t mk_resp(input logic [7:0] rd, input logic adr,
                                            input logic latch, input logic pw,
                                            input logic [2:0] pch, input logic [7:0] pval);
        slave_resp_t r;
        r.rdata = rd;
        r.addressed = adr;
        r.latch_reset = latch;
        r.pwm_written = pw;
        r.pwm_channel = pch;
        r.pwm_value = pval;
        return r;
    endfunction

    task automatic add_row(input slave_word_t w, input logic pinned, input slave_resp_t r);
        table_row_t row;
        row.pinned = pinned;
        row.word = w;
        row.resp = r;
        directed_rows.push_back(row);
    endtask

    // Present one word, hold it until taken, then queue its expected response
    task automatic send_word(input slave_word_t w, input logic pinned,
                             input slave_resp_t pinned_resp);
        slave_resp_t pred;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= w.command;
        dev_addr    <= w.dev_addr;
        reg_code    <= w.reg_code;
        wdata       <= w.wdata;
        has_payload <= w.has_payload;
        load_index  <= w.load_index;
        load_value  <= w.load_value;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
        pred = run_register_map(w);
        awaited_resp_q.push_back(pinned ? pinned_resp : pred);
        words_sent++;
    endtask

    // Drop valid, wait for every response, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (awaited_resp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four registers on consecutive edges while the slave is idle
    task automatic program_regs(input logic [7:0] dev, input logic [7:0] rev,
                                input logic [7:0] mlo, input logic [7:0] mhi);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEV_ADDR;
        cfg_wdata <= dev;
        @(posedge clk);
        cfg_index <= REG_SW_REV;
        cfg_wdata <= rev;
        @(posedge clk);
        cfg_index <= REG_MODE_LOW;
        cfg_wdata <= mlo;
        @(posedge clk);
        cfg_index <= REG_MODE_HIGH;
        cfg_wdata <= mhi;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_dev_addr = dev;
        cfg_sw_rev = rev;
        cfg_mode_low = mlo;
        cfg_mode_high = mhi;
        settings_used++;
    endtask

    // Receiver back-pressure
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Compare each taken response with the oldest expectation
    always @(posedge clk) begin : check_resp
        slave_resp_t exp_r;
        if (rst_n && out_valid && out_ready) begin
            if (awaited_resp_q.size() == 0) begin
                $error("response with nothing expected: rdata %h", rdata);
                errors++;
            end else begin
                exp_r = awaited_resp_q.pop_front();
                resps_checked++;
                if (rdata !== exp_r.rdata) begin
                    $error("rdata: expected %h, got %h", exp_r.rdata, rdata);
                    errors++;
                end
                if (addressed !== exp_r.addressed) begin
                    $error("addressed: expected %b, got %b", exp_r.addressed, addressed);
                    errors++;
                end
                if (latch_reset !== exp_r.latch_reset) begin
                    $error("latch_reset: expected %b, got %b", exp_r.latch_reset, latch_reset);
                    errors++;
                end
                if (pwm_written !== exp_r.pwm_written) begin
                    $error("pwm_written: expected %b, got %b", exp_r.pwm_written, pwm_written);
                    errors++;
                end
                if (pwm_channel !== exp_r.pwm_channel) begin
                    $error("pwm_channel: expected %0d, got %0d", exp_r.pwm_channel, pwm_channel);
                    errors++;
                end
                if (pwm_value !== exp_r.pwm_value) begin
                    $error("pwm_value: expected %h, got %h", exp_r.pwm_value, pwm_value);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        slave_word_t w;
        slave_resp_t none;
        int pick;
        none = '0;
        foreach (map_store[i]) map_store[i] = '0;
        foreach (map_pwm[i]) map_pwm[i] = '0;
        foreach (map_adc[i]) map_adc[i] = '0;
        foreach (map_gpio[i]) map_gpio[i] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        program_regs(8'h5A, 8'hA5, 8'h00, 8'hFF);

        // Directed words: rows with a typed response are checked against it
        add_row(mk_xfer(8'h5A, CODE_NOCHANGE, 1'b0, 8'h00), 1'b1,
                mk_resp(8'h00, 1'b1, 1'b0, 1'b0, 3'd0, 8'h00));
        add_row(mk_xfer(8'h5B, CODE_REV, 1'b1, 8'h42), 1'b1,
                mk_resp(8'h00, 1'b0, 1'b0, 1'b0, 3'd0, 8'h00));
        add_row(mk_xfer(8'h5A, CODE_REV, 1'b0, 8'h00), 1'b1,
                mk_resp(8'hA5, 1'b1, 1'b0, 1'b0, 3'd0, 8'h00));
        add_row(mk_xfer(8'h5A, CODE_PWM0, 1'b1, 8'hFF), 1'b1,
                mk_resp(8'hFF, 1'b1, 1'b0, 1'b1, 3'd0, 8'hFF));
        add_row(mk_xfer(8'h5A, CODE_PWM7, 1'b1, 8'h00), 1'b1,
                mk_resp(8'h00, 1'b1, 1'b0, 1'b1, 3'd7, 8'h00));
        // unused codes read as all ones and ignore writes
        add_row(mk_xfer(8'h5A, CODE_PWM7 + 8'd1, 1'b1, 8'h77), 1'b1,
                mk_resp(8'hFF, 1'b1, 1'b0, 1'b0, 3'd0, 8'h00));
        add_row(mk_xfer(8'h5A, CODE_ADC_FIRST - 8'd1, 1'b0, 8'h00), 1'b1,
                mk_resp(8'hFF, 1'b1, 1'b0, 1'b0, 3'd0, 8'h00));
        add_row(mk_load(CMD_ADC, 4'd0, 16'hFFFF), 1'b1,
                mk_resp(8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, 8'h00));
        add_row(mk_load(CMD_ADC, 4'd15, 16'h1234), 1'b1,
                mk_resp(8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, 8'h00));
        // low byte read locks the high byte against later loads
        add_row(mk_xfer(8'h5A, CODE_ADC_FIRST, 1'b0, 8'h00), 1'b1,
                mk_resp(8'hFF, 1'b1, 1'b0, 1'b0, 3'd0, 8'h00));
        add_row(mk_load(CMD_ADC, 4'd0, 16'h0000), 1'b1,
                mk_resp(8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, 8'h00));
        add_row(mk_xfer(8'h5A, CODE_ADC_FIRST + 8'd1, 1'b0, 8'h00), 1'b1,
                mk_resp(8'hFF, 1'b1, 1'b0, 1'b0, 3'd0, 8'h00));
        add_row(mk_xfer(8'h5A, CODE_ADC_LAST - 8'd1, 1'b1, 8'h99), 1'b0, none);
        add_row(mk_xfer(8'h5A, CODE_ADC_LAST, 1'b0, 8'h00), 1'b0, none);
        add_row(mk_load(CMD_GPIO, 4'd0, 16'hAB55), 1'b0, none);
        add_row(mk_load(CMD_GPIO, 4'd15, 16'h00FF), 1'b0, none);
        add_row(mk_load(CMD_GPIO, 4'd2, 16'h0080), 1'b0, none);
        add_row(mk_xfer(8'h5A, CODE_GPIO0, 1'b1, 8'h11), 1'b0, none);
        add_row(mk_xfer(8'h5A, CODE_GPIO1, 1'b1, 8'hEE), 1'b1,
                mk_resp(8'h00, 1'b1, 1'b1, 1'b0, 3'd0, 8'h00));
        add_row(mk_xfer(8'h5A, CODE_MODE0, 1'b0, 8'h00), 1'b1,
                mk_resp(8'h00, 1'b1, 1'b0, 1'b0, 3'd0, 8'h00));
        add_row(mk_xfer(8'h5A, CODE_MODE1, 1'b0, 8'h00), 1'b1,
                mk_resp(8'hFF, 1'b1, 1'b0, 1'b0, 3'd0, 8'h00));
        add_row(mk_xfer(8'h5A, CODE_SOFTOC, 1'b0, 8'h00), 1'b0, none);
        // debug byte reads as all ones while zero
        add_row(mk_xfer(8'h5A, CODE_DEBUG, 1'b0, 8'h00), 1'b1,
                mk_resp(8'hFF, 1'b1, 1'b0, 1'b0, 3'd0, 8'h00));
        add_row(mk_xfer(8'h5A, CODE_DEBUG, 1'b1, 8'h3C), 1'b1,
                mk_resp(8'h3C, 1'b1, 1'b0, 1'b0, 3'd0, 8'h00));
        add_row(mk_xfer(8'h5A, 8'hFF, 1'b1, 8'hAA), 1'b1,
                mk_resp(8'hFF, 1'b1, 1'b0, 1'b0, 3'd0, 8'h00));
        w = mk_xfer(8'h5A, CODE_REV, 1'b1, 8'h00);
        w.command = CMD_IGNORED;
        add_row(w, 1'b1, mk_resp(8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, 8'h00));

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].pinned, directed_rows[i].resp);
        settle();

        // Random phases: new register settings and a new idling mode each
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: program_regs(8'h00, 8'hFF, 8'hFF, 8'h00);
                1: program_regs(8'hFF, 8'h00, 8'h00, 8'hFF);
                default: program_regs(8'($urandom), 8'($urandom), 8'($urandom),
                                      8'($urandom));
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                w.command = CMD_XFER;
                w.dev_addr = 8'($urandom);
                w.reg_code = 8'($urandom);
                w.wdata = 8'($urandom);
                w.has_payload = 1'($urandom);
                w.load_index = LIDX_W'($urandom);
                w.load_value = SAMPLE_W'($urandom);
                pick = $urandom_range(99);
                if (pick < 60) begin
                    // mostly addressed transactions over the live part of the map
                    if ($urandom_range(99) < 85)
                        w.dev_addr = cfg_dev_addr;
                    case ($urandom_range(9))
                        0: w.reg_code = $urandom_range(1) ? CODE_REV : CODE_NOCHANGE;
                        1, 2: w.reg_code = 8'(CODE_PWM0 + $urandom_range(7));
                        3, 4: w.reg_code = 8'(CODE_ADC_FIRST +
                                              $urandom_range(CODE_ADC_LAST - CODE_ADC_FIRST));
                        5: w.reg_code = 8'(CODE_GPIO0 +
                                           $urandom_range(CODE_SOFTOC - CODE_GPIO0));
                        6: w.reg_code = CODE_DEBUG;
                        7: w.reg_code = 8'(CODE_PWM7 + 1 +
                                           $urandom_range(CODE_ADC_FIRST - CODE_PWM7 - 2));
                        default: ;
                    endcase
                end else if (pick < 78) begin
                    w.command = CMD_ADC;
                    if ($urandom_range(9) == 0)
                        w.load_value = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                end else if (pick < 95) begin
                    w.command = CMD_GPIO;
                    if ($urandom_range(3) != 0)
                        w.load_index = LIDX_W'($urandom_range(GPIO_BYTES - 1));
                end else begin
                    w.command = CMD_IGNORED;
                end
                send_word(w, 1'b0, none);
            end
            settle();
        end

        $display("covered %0d words (%0d directed) over %0d register settings,",
                 words_sent, directed_rows.size(), settings_used);
        $display("with four idling modes; %0d responses compared", resps_checked);
        if (errors == 0)
            $display("i2c_register_map_slave_top: match");
        else
            $display("i2c_register_map_slave_top: mismatch");
        $finish;
    end

    // End a hung run
    initial begin
        #(LIMIT_NS);
        $display("i2c_register_map_slave_top: mismatch");
        $finish;
    end

endmodule
